>>> rtl/htfd_pkg.sv
package htfd_pkg;

    // Scale constants for the fixed-point conversion
    localparam int TEMP_SCALE  = 17500;
    localparam int HUMID_SCALE = 10000;
    localparam int TEMP_OFFSET = 4500;
    localparam int FULL_SCALE  = 65535;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int TEMP_W  = 15;
    localparam int HUMID_W = 14;
    localparam int DATA_W  = 8;
    localparam int OUT_W   = 64;

    // Default depth of the frame queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One decoded frame, as handed from front to back
    typedef struct packed {
        logic [RAW_W-1:0] temp_raw;
        logic [RAW_W-1:0] humid_raw;
        logic             status;
    } frame_t;

endpackage

>>> rtl/humidity_temp_frame_decoder.sv
// Channel  Dir  tdata                                        tuser
// s_       in   [7:0] data_byte                              [0] frame_start
// m_       out  [15:0] temp_raw, [31:16] humid_raw,          [0] status
//               [46:32] temp_centi, [60:47] humid_centi
//
// One byte word is accepted per cycle; s_tready drops only while the frame queue is full.
// A result word appears on m_ after the sixth byte of a frame is accepted, by way of the
// queue write at that edge, the product stage, then the divide-by-65535 correction into
// the output register.
// aresetn is synchronous and active low; it clears the frame position, CRC and queue.
// A stalled m_ side fills the queue; once it holds QUEUE_DEPTH frames s_tready stays low
// until the back end pops one.
module humidity_temp_frame_decoder #(
    parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [htfd_pkg::DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [htfd_pkg::OUT_W-1:0]    m_tdata,   // [15:0] temp_raw, [31:16] humid_raw,
                                                     // [46:32] temp_centi, [60:47] humid_centi
    output logic                          m_tuser    // [0] status
);
    import htfd_pkg::*;

    logic   push;
    frame_t push_data;
    logic   queue_full;
    logic   pop;
    logic   q_valid;
    frame_t q_data;

    // Byte sequencing and CRC check
    htfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // Decoupling queue of finished frames
    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    // Scaling and output
    htfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_data  (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/htfd_front.sv
module htfd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [htfd_pkg::DATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] frame_start
    output logic                            push,
    output htfd_pkg::frame_t                push_data,
    input  logic                            queue_full
);
    import htfd_pkg::*;

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [RAW_W-1:0] hold_reg, hold_next;
    logic [RAW_W-1:0] temp_word_reg, temp_word_next;
    logic             temp_good_reg, temp_good_next;

    logic             accept;
    logic [2:0]       pos_eff;
    logic [7:0]       crc_in;
    logic [7:0]       crc_new;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // Effective position: start flag and stray codes go to byte 0
    always_comb begin
        if (s_tuser || (pos_reg > POS_H_CRC)) begin
            pos_eff = POS_T_HI;
        end else begin
            pos_eff = pos_reg;
        end
    end

    assign crc_in  = (pos_eff == POS_T_HI || pos_eff == POS_H_HI) ? CRC_INIT : crc_reg;
    assign crc_new = crc8_byte(crc_in, s_tdata);

    // Frame sequencing
    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        hold_next      = hold_reg;
        temp_word_next = temp_word_reg;
        temp_good_next = temp_good_reg;
        push           = 1'b0;
        if (accept) begin
            unique case (pos_eff)
                POS_T_HI, POS_H_HI: begin
                    hold_next = {s_tdata, 8'h00};
                    crc_next  = crc_new;
                    pos_next  = pos_eff + 3'd1;
                end
                POS_T_LO, POS_H_LO: begin
                    hold_next = {hold_reg[RAW_W-1:8], s_tdata};
                    crc_next  = crc_new;
                    pos_next  = pos_eff + 3'd1;
                end
                POS_T_CRC: begin
                    temp_good_next = (crc_reg == s_tdata);
                    temp_word_next = hold_reg;
                    pos_next       = POS_H_HI;
                end
                default: begin
                    push     = 1'b1;
                    pos_next = POS_T_HI;
                end
            endcase
        end
    end

    // Finished frame record
    assign push_data.temp_raw  = temp_word_reg;
    assign push_data.humid_raw = hold_reg;
    assign push_data.status    = !(temp_good_reg && (crc_reg == s_tdata));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            hold_reg      <= '0;
            temp_word_reg <= '0;
            temp_good_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            hold_reg      <= hold_next;
            temp_word_reg <= temp_word_next;
            temp_good_reg <= temp_good_next;
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_H_CRC)
        else $error("frame position out of range");

    a_push_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> pos_reg == POS_T_HI)
        else $error("frame pushed without wrapping to byte 0");

endmodule

>>> rtl/htfd_queue.sv
module htfd_queue #(
    parameter int DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  htfd_pkg::frame_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             out_valid,
    output htfd_pkg::frame_t out_data
);
    import htfd_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t            mem_reg [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop) && !(pop && !out_valid))
        else $error("frame queue overflow or underflow");

endmodule

>>> rtl/htfd_back.sv
module htfd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  htfd_pkg::frame_t             in_data,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [htfd_pkg::OUT_W-1:0]   m_tdata,   // [15:0] temp_raw, [31:16] humid_raw,
                                                    // [46:32] temp_centi, [60:47] humid_centi
    output logic                         m_tuser    // [0] status
);
    import htfd_pkg::*;

    localparam int TPROD_W = 31;
    localparam int HPROD_W = 30;
    localparam int PAD_W   = OUT_W - 2 * RAW_W - TEMP_W - HUMID_W;

    // Stage 1: constant products
    logic               s1_valid_reg;
    frame_t             s1_frame_reg;
    logic [TPROD_W-1:0] s1_tprod_reg;
    logic [HPROD_W-1:0] s1_hprod_reg;

    // Stage 2: output register
    logic               s2_valid_reg;
    frame_t             s2_frame_reg;
    logic [TEMP_W-1:0]  s2_temp_reg, s2_temp_next;
    logic [HUMID_W-1:0] s2_humid_reg, s2_humid_next;

    logic               s2_load;
    logic               s1_free;

    logic [TEMP_W-1:0]  tq_est;
    logic [RAW_W:0]     t_rem;
    logic [TEMP_W-1:0]  tq;
    logic [HUMID_W-1:0] hq_est;
    logic [RAW_W:0]     h_rem;
    logic [HUMID_W-1:0] hq;

    assign s2_load = s1_valid_reg && (!s2_valid_reg || m_tready);
    assign s1_free = !s1_valid_reg || s2_load;
    assign pop     = in_valid && s1_free;

    // Divide by 65535: quotient estimate p>>16, remainder (p & 0xFFFF) + estimate
    assign tq_est = s1_tprod_reg[TPROD_W-1:RAW_W];
    assign t_rem  = {1'b0, s1_tprod_reg[RAW_W-1:0]} + (RAW_W+1)'(tq_est);
    assign tq     = (t_rem >= (RAW_W+1)'(FULL_SCALE)) ? tq_est + 1'b1 : tq_est;

    assign hq_est = s1_hprod_reg[HPROD_W-1:RAW_W];
    assign h_rem  = {1'b0, s1_hprod_reg[RAW_W-1:0]} + (RAW_W+1)'(hq_est);
    assign hq     = (h_rem >= (RAW_W+1)'(FULL_SCALE)) ? hq_est + 1'b1 : hq_est;

    assign s2_temp_next  = tq - TEMP_W'(TEMP_OFFSET);
    assign s2_humid_next = hq;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= in_valid;
            end
            if (!s2_valid_reg || m_tready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_frame_reg <= in_data;
            s1_tprod_reg <= TPROD_W'(in_data.temp_raw) * TPROD_W'(TEMP_SCALE);
            s1_hprod_reg <= HPROD_W'(in_data.humid_raw) * HPROD_W'(HUMID_SCALE);
        end
        if (s2_load) begin
            s2_frame_reg <= s1_frame_reg;
            s2_temp_reg  <= s2_temp_next;
            s2_humid_reg <= s2_humid_next;
        end
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, s2_humid_reg, s2_temp_reg,
                       s2_frame_reg.humid_raw, s2_frame_reg.temp_raw};
    assign m_tuser  = s2_frame_reg.status;

    a_humid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> s2_humid_reg <= HUMID_W'(HUMID_SCALE))
        else $error("humidity above full scale");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(s2_temp_reg) >= -$signed(TEMP_W'(TEMP_OFFSET)))
                  && ($signed(s2_temp_reg) <= $signed(TEMP_W'(TEMP_SCALE - TEMP_OFFSET))))
        else $error("temperature out of range");

endmodule

>>> test/humidity_temp_frame_decoder_tb.sv
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_tb;
    import htfd_pkg::*;

    // Status codes carried on m_tuser
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    // Sensor CRC-8 parameters
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_SEED = 8'hFF;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int TAIL_CYCLES        = 12;
    localparam int BYTES_PER_PHASE    = 135;
    localparam int MAX_REPORTS        = 10;

    typedef struct packed {
        logic [RAW_W-1:0]   temp_raw;
        logic [RAW_W-1:0]   humid_raw;
        logic [TEMP_W-1:0]  temp_centi;
        logic [HUMID_W-1:0] humid_centi;
        logic               status;
    } frame_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [DATA_W-1:0] s_tdata  = '0;     // [7:0] data_byte
    logic              s_tuser  = 1'b0;   // [0] frame_start
    logic              m_tready = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [OUT_W-1:0]  m_tdata;           // [15:0] temp_raw, [31:16] humid_raw,
                                          // [46:32] temp_centi, [60:47] humid_centi
    logic              m_tuser;           // [0] status

    // Predictor state, mirrors the decoder after reset
    logic [2:0]        frame_pos   = 3'd0;
    logic [7:0]        crc_run     = CRC_SEED;
    logic [RAW_W-1:0]  word_acc    = '0;
    logic [RAW_W-1:0]  temp_word_q = '0;
    logic              temp_ok     = 1'b0;

    frame_result_t pending_frames[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int bytes_sent      = 0;
    int frames_checked  = 0;
    int crc_fail_frames = 0;

    humidity_temp_frame_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_count, pending_frames.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // CRC-8, MSB first, one byte folded in
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // Advance the predictor by one accepted byte; queue a result after the sixth
    task automatic frame_decode_step(input logic [7:0] b, input logic start);
        logic [2:0]    pos;
        logic [7:0]    crc_in;
        logic [31:0]   tq;
        logic [31:0]   hq;
        frame_result_t r;
        pos = start ? 3'd0 : frame_pos;
        if (pos > 3'd5)
            pos = 3'd0;
        crc_in = (pos == 3'd0 || pos == 3'd3) ? CRC_SEED : crc_run;
        case (pos)
            3'd0, 3'd3: begin
                word_acc  = {b, 8'h00};
                crc_run   = crc8_fold(crc_in, b);
                frame_pos = pos + 3'd1;
            end
            3'd1, 3'd4: begin
                word_acc[7:0] = b;
                crc_run       = crc8_fold(crc_in, b);
                frame_pos     = pos + 3'd1;
            end
            3'd2: begin
                temp_ok     = (crc_run == b);
                temp_word_q = word_acc;
                frame_pos   = 3'd3;
            end
            default: begin
                tq = (32'(TEMP_SCALE) * 32'(temp_word_q)) / 32'(FULL_SCALE);
                hq = (32'(HUMID_SCALE) * 32'(word_acc)) / 32'(FULL_SCALE);
                r.temp_raw    = temp_word_q;
                r.humid_raw   = word_acc;
                r.temp_centi  = TEMP_W'(tq - 32'(TEMP_OFFSET));
                r.humid_centi = HUMID_W'(hq);
                r.status      = (temp_ok && crc_run == b) ? STATUS_OK : STATUS_CRC_ERR;
                pending_frames.push_back(r);
                frame_pos = 3'd0;
            end
        endcase
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            note_error($sformatf("result %0d %s expected %h got %h",
                                 frames_checked, name, want, got));
    endtask

    // Result checker: oldest expectation against each accepted result word
    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.temp_raw    = m_tdata[15:0];
            got.humid_raw   = m_tdata[31:16];
            got.temp_centi  = m_tdata[46:32];
            got.humid_centi = m_tdata[60:47];
            got.status      = m_tuser;
            if (pending_frames.size() == 0) begin
                note_error($sformatf("unexpected result word %h status %b", m_tdata, m_tuser));
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (want.status == STATUS_CRC_ERR)
                    crc_fail_frames++;
                compare_field("temp_raw", want.temp_raw, got.temp_raw);
                compare_field("humid_raw", want.humid_raw, got.humid_raw);
                compare_field("temp_centi", want.temp_centi, got.temp_centi);
                compare_field("humid_centi", want.humid_centi, got.humid_centi);
                compare_field("status", want.status, got.status);
            end
        end
    end

    // Send one byte word; valid stays up until the next call decides
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        frame_decode_step(b, start);
        bytes_sent++;
    endtask

    // Full six-byte frame, optionally with corrupted CRC bytes
    task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                              input logic start, input logic t_bad, input logic h_bad);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = crc8_fold(crc8_fold(CRC_SEED, t[15:8]), t[7:0]);
        hc = crc8_fold(crc8_fold(CRC_SEED, h[15:8]), h[7:0]);
        if (t_bad)
            tc ^= 8'($urandom_range(1, 255));
        if (h_bad)
            hc ^= 8'($urandom_range(1, 255));
        send_byte(t[15:8], start);
        send_byte(t[7:0], 1'b0);
        send_byte(tc, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(hc, 1'b0);
    endtask

    // Drop valid and wait for every queued result
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_frames.size() != 0);
    endtask

    function automatic logic [15:0] pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return 16'h0000;
        if (sel < 16)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic apply_reset();
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // Extremes, CRC errors, resync by start flag, back-to-back frames
    task automatic test_directed_frames();
        send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        // no start flag: position wraps after byte 5
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b0);
        // partial frame, restarted twice, then dropped
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
    endtask

    // Sender stops until the result side has caught up
    task automatic test_drain_pause();
        send_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0);
        hold_until_drained();
        send_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b0);
    endtask

    // Mostly good frames, some broken sequences and loose noise bytes
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        int target;
        int pick;
        int len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = bytes_sent + n;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                send_frame(pick_word(), pick_word(),
                           (frame_pos != 3'd0) || ($urandom_range(1) == 1),
                           $urandom_range(99) < 12, $urandom_range(99) < 12);
            end else if (pick < 90) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom), (i == 0) ? 1'($urandom_range(1)) : 1'b0);
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom), $urandom_range(99) < 25);
            end
        end
    endtask

    initial begin
        apply_reset();
        send_idle_pct = 27;
        recv_idle_pct = 60;
        test_directed_frames();
        test_random_traffic(27, 60, BYTES_PER_PHASE);
        test_drain_pause();
        test_random_traffic(60, 27, BYTES_PER_PHASE);
        test_random_traffic(0, 0, BYTES_PER_PHASE);

        // let the pipeline flush, watch for stray results
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_frames.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_frames.size()));

        $display("Sent %0d bytes; checked %0d decoded frames, %0d of them with CRC errors,",
                 bytes_sent, frames_checked, crc_fail_frames);
        $display("across three sender/receiver stall mixes and a full drain pause.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
